// File: rtl/set_pkg.sv
// ----------------------------------------------------------------------------
// set_pkg: shared types and constants for the session expiry table
//   Field widths, command and status codes, register map.
// ----------------------------------------------------------------------------
package set_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned IdW      = 64;
  localparam int unsigned TmoW     = 32;
  localparam int unsigned NowW     = 47;
  localparam int unsigned ExpW     = 48;
  localparam int unsigned IvW      = 16;
  localparam int unsigned SumW     = 48;
  localparam int unsigned PaddrW   = 1;

  localparam logic [IvW-1:0] IntervalReset = 16'd500;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LIST   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_FULL     = 3'd2,
    ST_EXPIRED  = 3'd3,
    ST_NONE     = 3'd4
  } status_e;

  localparam logic [PaddrW-1:0] RegInterval = 1'b0;

endpackage

// File: rtl/session_expiry_table_unit.sv
// ----------------------------------------------------------------------------
// session_expiry_table_unit: bucketed session expiry table
//   Input channel carries cmd/sid/ttl_ms/now_ms; output channel returns
//   sid_res/status/last. One command at a time.
//   Add: a restoring divider (one bit a cycle) yields the remainder, the
//   rounding state rounds the expiry up to the bucket, then a scan (one
//   registered table read a cycle, one shared compare) finds the id or the
//   lowest free entry. Remove: one scan. Clear: clears the valid bits and
//   goes straight to the output state. List: a scan marks pending entries;
//   each listed item then takes one minimum search plus one pass through the
//   output state; when none expired, the marking scan leads straight to the
//   output state.
//   Results go through one output register; while it is full and the receiver
//   stalls, the sequencer holds in its output state. in_ready_o is high only
//   in the idle state; the last result may still wait in the output register.
//   Reset clears all valid bits and sets interval_ms to 500; no sweep needed.
//   The APB port has pready tied high; interval_ms lies at address 0, and an
//   interval of 0 acts as 1.
// ----------------------------------------------------------------------------
module session_expiry_table_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [set_pkg::PaddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     cmd_i,
  input  logic signed [set_pkg::IdW-1:0] sid_i,
  input  logic [set_pkg::TmoW-1:0]       ttl_ms_i,
  input  logic [set_pkg::NowW-1:0]       now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [set_pkg::IdW-1:0] sid_res_o,
  output logic [2:0]                     status_o,
  output logic                           last_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_RND   = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_COUNT = 7'b0010000,
    S_MIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  localparam int unsigned IdxW = set_pkg::IdxW;
  localparam int unsigned CntW = set_pkg::CntW;
  // scan index runs one past the last entry to drain the registered read
  localparam logic [IdxW:0] ScanEnd = (IdxW+1)'(set_pkg::Capacity + 1);

  state_e state_q, state_d;
  logic [set_pkg::IvW-1:0]  interval_q;
  logic [set_pkg::Capacity-1:0] valid_q, pend_q;
  logic [set_pkg::IdW-1:0]  ent_id_q [set_pkg::Capacity];
  logic [set_pkg::ExpW-1:0] ent_exp_q [set_pkg::Capacity];
  logic [set_pkg::IdW-1:0]  rd_id_q;
  logic [set_pkg::ExpW-1:0] rd_exp_q;

  logic [1:0]               cmd_q;
  logic [set_pkg::IdW-1:0]  id_q;
  logic [set_pkg::NowW-1:0] now_q;
  logic [set_pkg::SumW-1:0] sum_q;
  logic [set_pkg::SumW-1:0] dividend_q;
  logic [set_pkg::IvW:0]    rem_q;
  logic [5:0]               step_q;
  logic [set_pkg::ExpW-1:0] exp_q;
  logic [IdxW:0]            idx_q;
  logic                     hit_q, free_q;
  logic [IdxW-1:0]          hit_idx_q, free_idx_q, best_q;
  logic                     best_ok_q;
  logic [set_pkg::IdW-1:0]  best_id_q;
  logic [set_pkg::ExpW-1:0] best_exp_q;
  logic [CntW-1:0]          left_q;
  logic                     more_q;

  logic                     ov_q;
  logic [set_pkg::IdW-1:0]  res_id_q;
  logic [2:0]               res_st_q;
  logic                     res_last_q;
  logic [set_pkg::IdW-1:0]  out_id_q;
  logic [2:0]               out_st_q;
  logic                     out_last_q;

  logic [set_pkg::IvW-1:0]  iv;
  logic [IdxW-1:0]          ci, di;
  logic [set_pkg::IvW:0]    rem_sh;
  logic [set_pkg::SumW-1:0] in_sum;
  logic [set_pkg::ExpW:0]   rnd_sum;
  logic                     id_eq, due, before_best;
  logic                     scan_end, scan_data, out_free;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign prdata = (paddr == set_pkg::RegInterval) ? {16'd0, interval_q} : 32'd0;
  assign cfg_wr = psel & penable & pwrite;
  assign iv     = (interval_q == '0) ? {{(set_pkg::IvW-1){1'b0}}, 1'b1} : interval_q;
  assign ci     = idx_q[IdxW-1:0];
  // entry whose registered read data is present this cycle
  assign di     = ci - IdxW'(1);
  assign scan_end  = (idx_q == ScanEnd);
  assign scan_data = (idx_q != '0) && !scan_end;
  assign out_free  = !ov_q || out_ready_i;
  assign rem_sh = {rem_q[set_pkg::IvW-1:0], dividend_q[set_pkg::SumW-1]};
  assign in_sum = {1'b0, now_ms_i} + {16'd0, ttl_ms_i};
  // (q+1)*iv = sum - rem + iv
  assign rnd_sum = {1'b0, sum_q}
                 - {{(set_pkg::ExpW-set_pkg::IvW){1'b0}}, rem_q}
                 + {{(set_pkg::ExpW-set_pkg::IvW+1){1'b0}}, iv};
  assign id_eq  = valid_q[di] && (rd_id_q == id_q);
  assign due    = valid_q[di] && (rd_exp_q <= {1'b0, now_q});
  always_comb begin
    if (rd_exp_q != best_exp_q) begin
      before_best = rd_exp_q < best_exp_q;
    end else begin
      before_best = $signed(rd_id_q) < $signed(best_id_q);
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign sid_res_o   = out_id_q;
  assign status_o    = out_st_q;
  assign last_o      = out_last_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            set_pkg::CMD_ADD:    state_d = S_DIV;
            set_pkg::CMD_REMOVE: state_d = S_SCAN;
            set_pkg::CMD_LIST:   state_d = S_COUNT;
            default:             state_d = S_OUT;
          endcase
        end
      end
      S_DIV:   if (step_q == 6'd47) state_d = S_RND;
      S_RND:   state_d = S_SCAN;
      S_SCAN:  if (scan_end) state_d = S_OUT;
      S_COUNT: if (scan_end) state_d = (left_q != '0) ? S_MIN : S_OUT;
      S_MIN:   if (scan_end) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = more_q ? S_MIN : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      interval_q <= set_pkg::IntervalReset;
      valid_q    <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && paddr == set_pkg::RegInterval) interval_q <= pwdata[15:0];
      if (state_q == S_OUT && out_free) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i && cmd_i == set_pkg::CMD_CLEAR) valid_q <= '0;
        S_SCAN: begin
          if (scan_end) begin
            if (cmd_q == set_pkg::CMD_REMOVE && hit_q) valid_q[hit_idx_q] <= 1'b0;
            if (cmd_q == set_pkg::CMD_ADD && !hit_q && free_q)
              valid_q[free_idx_q] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_id_q  <= ent_id_q[ci];
    rd_exp_q <= ent_exp_q[ci];
    case (state_q)
      S_IDLE: begin
        cmd_q      <= cmd_i;
        id_q       <= sid_i;
        now_q      <= now_ms_i;
        sum_q      <= in_sum;
        dividend_q <= in_sum;
        rem_q      <= '0;
        step_q     <= '0;
        idx_q      <= '0;
        hit_q      <= 1'b0;
        free_q     <= 1'b0;
        best_ok_q  <= 1'b0;
        left_q     <= '0;
        more_q     <= 1'b0;
        res_id_q   <= sid_i;
        res_st_q   <= set_pkg::ST_DONE;
        res_last_q <= 1'b1;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, iv}) begin
          rem_q <= rem_sh - {1'b0, iv};
        end else begin
          rem_q <= rem_sh;
        end
        dividend_q <= {dividend_q[set_pkg::SumW-2:0], 1'b0};
        step_q     <= step_q + 6'd1;
      end
      S_RND: begin
        if (rnd_sum[set_pkg::ExpW]) exp_q <= {set_pkg::ExpW{1'b1}};
        else exp_q <= rnd_sum[set_pkg::ExpW-1:0];
      end
      S_SCAN: begin
        if (!scan_end) begin
          if (scan_data) begin
            if (id_eq && !hit_q) begin
              hit_q     <= 1'b1;
              hit_idx_q <= di;
            end
            if (!valid_q[di] && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= di;
            end
          end
          idx_q <= idx_q + (IdxW+1)'(1);
        end else begin
          res_id_q <= id_q;
          if (cmd_q == set_pkg::CMD_REMOVE) begin
            res_st_q <= hit_q ? set_pkg::ST_DONE : set_pkg::ST_NOTFOUND;
          end else if (hit_q) begin
            ent_exp_q[hit_idx_q] <= exp_q;
          end else if (free_q) begin
            ent_id_q[free_idx_q]  <= id_q;
            ent_exp_q[free_idx_q] <= exp_q;
          end else begin
            res_st_q <= set_pkg::ST_FULL;
          end
        end
      end
      S_COUNT: begin
        if (!scan_end) begin
          if (scan_data) begin
            pend_q[di] <= due;
            if (due) left_q <= left_q + CntW'(1);
          end
          idx_q <= idx_q + (IdxW+1)'(1);
        end else begin
          // only used when nothing expired; otherwise the selection scans run
          res_st_q   <= set_pkg::ST_NONE;
          res_last_q <= 1'b1;
          more_q     <= 1'b0;
          idx_q      <= '0;
          best_ok_q  <= 1'b0;
        end
      end
      S_MIN: begin
        if (!scan_end) begin
          if (scan_data && pend_q[di] && (!best_ok_q || before_best)) begin
            best_q     <= di;
            best_id_q  <= rd_id_q;
            best_exp_q <= rd_exp_q;
            best_ok_q  <= 1'b1;
          end
          idx_q <= idx_q + (IdxW+1)'(1);
        end else begin
          pend_q[best_q] <= 1'b0;
          res_id_q       <= best_id_q;
          res_st_q       <= set_pkg::ST_EXPIRED;
          res_last_q     <= (left_q == CntW'(1));
          left_q         <= left_q - CntW'(1);
          more_q         <= (left_q != CntW'(1));
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_id_q   <= res_id_q;
          out_st_q   <= res_st_q;
          out_last_q <= res_last_q;
          if (more_q) begin
            idx_q     <= '0;
            best_ok_q <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: bench/session_expiry_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_expiry_table_unit_tb: self-checking bench for the session table
//   Drives commands over valid/ready, predicts every result with a local
//   copy of the table, and checks each output transfer in order. Includes
//   directed corner cases, interval changes over APB and random traffic.
// ----------------------------------------------------------------------------
module session_expiry_table_unit_tb;

  localparam int unsigned HangLimit = 20000;
  localparam int unsigned Capacity  = set_pkg::Capacity;
  localparam int unsigned IdW       = set_pkg::IdW;
  localparam int unsigned TmoW      = set_pkg::TmoW;
  localparam int unsigned NowW      = set_pkg::NowW;
  localparam int unsigned ExpW      = set_pkg::ExpW;
  localparam int unsigned IvW       = set_pkg::IvW;

  typedef struct packed {
    logic [IdW-1:0]   id;
    set_pkg::status_e status;
    logic             last;
  } sess_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [set_pkg::PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = set_pkg::CMD_CLEAR;
  logic signed [IdW-1:0] sid_i = '0;
  logic [TmoW-1:0] ttl_ms_i = '0;
  logic [NowW-1:0] now_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [IdW-1:0] sid_res_o;
  logic [2:0] status_o;
  logic last_o;

  always #4 clk_i = ~clk_i;

  session_expiry_table_unit i_dut (.*);

  // local copy of the table
  logic [IvW-1:0] bucket_ms;
  logic           tbl_used [Capacity];
  logic [IdW-1:0] tbl_id   [Capacity];
  logic [ExpW-1:0] tbl_exp [Capacity];

  sess_result_t expected_results[$];
  int unsigned  mismatches = 0;
  bit           stall_free = 1'b0;
  int unsigned  idle_cycles = 0;
  logic signed [IdW-1:0] id_pool[8];

  task automatic report(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic logic [ExpW-1:0] bucket_expiry(logic [NowW-1:0] now,
                                                    logic [TmoW-1:0] tmo);
    logic [63:0] iv, sum, r;
    iv = (bucket_ms == 0) ? 64'd1 : 64'(bucket_ms);
    sum = 64'(now) + 64'(tmo);
    r = (sum / iv + 64'd1) * iv;
    return (r > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : r[ExpW-1:0];
  endfunction

  function automatic bit orders_first(int a, int b);
    if (tbl_exp[a] != tbl_exp[b]) return tbl_exp[a] < tbl_exp[b];
    return $signed(tbl_id[a]) < $signed(tbl_id[b]);
  endfunction

  function automatic void predict_command(set_pkg::cmd_e cmd, logic [IdW-1:0] id,
                                          logic [TmoW-1:0] tmo,
                                          logic [NowW-1:0] now);
    int hit, slot, best, cnt;
    bit due[Capacity];
    hit = -1;
    slot = -1;
    cnt = 0;
    for (int i = 0; i < Capacity; i++)
      if (tbl_used[i] && tbl_id[i] == id && hit < 0) hit = i;
    case (cmd)
      set_pkg::CMD_ADD: begin
        if (hit >= 0) begin
          tbl_exp[hit] = bucket_expiry(now, tmo);
          expected_results.push_back('{id, set_pkg::ST_DONE, 1'b1});
        end else begin
          for (int i = Capacity - 1; i >= 0; i--) if (!tbl_used[i]) slot = i;
          if (slot < 0) begin
            expected_results.push_back('{id, set_pkg::ST_FULL, 1'b1});
          end else begin
            tbl_used[slot] = 1'b1;
            tbl_id[slot] = id;
            tbl_exp[slot] = bucket_expiry(now, tmo);
            expected_results.push_back('{id, set_pkg::ST_DONE, 1'b1});
          end
        end
      end
      set_pkg::CMD_REMOVE: begin
        if (hit >= 0) begin
          tbl_used[hit] = 1'b0;
          expected_results.push_back('{id, set_pkg::ST_DONE, 1'b1});
        end else begin
          expected_results.push_back('{id, set_pkg::ST_NOTFOUND, 1'b1});
        end
      end
      set_pkg::CMD_CLEAR: begin
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        expected_results.push_back('{id, set_pkg::ST_DONE, 1'b1});
      end
      default: begin
        for (int i = 0; i < Capacity; i++) begin
          due[i] = tbl_used[i] && tbl_exp[i] <= 48'(now);
          if (due[i]) cnt++;
        end
        if (cnt == 0) expected_results.push_back('{id, set_pkg::ST_NONE, 1'b1});
        for (int n = 0; n < cnt; n++) begin
          best = -1;
          for (int i = 0; i < Capacity; i++)
            if (due[i] && (best < 0 || orders_first(i, best))) best = i;
          due[best] = 1'b0;
          expected_results.push_back('{tbl_id[best], set_pkg::ST_EXPIRED, n == cnt - 1});
        end
      end
    endcase
  endfunction

  task automatic maybe_idle();
    while (!stall_free && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // valid stays up after the transfer until the next call drives or idles
  task automatic send_command(set_pkg::cmd_e cmd, logic [IdW-1:0] id,
                              logic [TmoW-1:0] tmo, logic [NowW-1:0] now);
    maybe_idle();
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    sid_i <= id;
    ttl_ms_i <= tmo;
    now_ms_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    predict_command(cmd, id, tmo, now);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_interval(logic [31:0] value);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= set_pkg::RegInterval; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    bucket_ms = value[IvW-1:0];
    @(negedge clk_i);
    if (prdata[IvW-1:0] != value[IvW-1:0]) report("interval readback");
  endtask

  // output side: random backpressure, compare each transfer
  always @(negedge clk_i)
    out_ready_i <= stall_free || ($urandom_range(99) >= 13);

  always @(posedge clk_i) begin
    sess_result_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result id=%0d", sid_res_o));
      end else begin
        want = expected_results.pop_front();
        if (sid_res_o !== want.id)
          report($sformatf("id %0d want %0d", sid_res_o, $signed(want.id)));
        if (status_o !== want.status)
          report($sformatf("status %0d want %0d", status_o, want.status));
        if (last_o !== want.last)
          report($sformatf("last %0b want %0b", last_o, want.last));
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= HangLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_command(set_pkg::CMD_LIST, 64'h8000_0000_0000_0000, '0, '0);
    send_command(set_pkg::CMD_REMOVE, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    send_command(set_pkg::CMD_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, {NowW{1'b1}});
    send_command(set_pkg::CMD_ADD, 64'h8000_0000_0000_0000, 32'd0, 47'd0);
    send_command(set_pkg::CMD_ADD, 64'd5, 32'd100, 47'd0);
    send_command(set_pkg::CMD_ADD, -64'sd5, 32'd100, 47'd0);
    send_command(set_pkg::CMD_ADD, 64'd5, 32'd700, 47'd0);   // update in place
    send_command(set_pkg::CMD_LIST, 64'd9, '0, 47'd500);
    send_command(set_pkg::CMD_LIST, 64'd9, '0, 47'd2000);
    send_command(set_pkg::CMD_REMOVE, -64'sd5, '0, '0);
    send_command(set_pkg::CMD_REMOVE, -64'sd5, '0, '0);
    send_command(set_pkg::CMD_LIST, 64'd1, '0, {NowW{1'b1}});
    send_command(set_pkg::CMD_CLEAR, 64'd3, '0, '0);
    send_command(set_pkg::CMD_LIST, 64'd4, '0, {NowW{1'b1}});
  endtask

  task automatic test_full_table();
    for (int i = 0; i < Capacity; i++)
      send_command(set_pkg::CMD_ADD, 64'(i * 3 - 90), 32'($urandom_range(3000)), 47'd0);
    send_command(set_pkg::CMD_ADD, 64'd12345, 32'd0, 47'd0);     // no free entry
    send_command(set_pkg::CMD_ADD, -64'sd90, 32'd10, 47'd0);     // update while full
    send_command(set_pkg::CMD_REMOVE, 64'd0, '0, '0);
    send_command(set_pkg::CMD_ADD, 64'd777, 32'd0, 47'd0);       // lowest free entry
    send_command(set_pkg::CMD_LIST, 64'd0, '0, 47'd4000);
    send_command(set_pkg::CMD_CLEAR, 64'd0, '0, '0);
  endtask

  task automatic test_intervals();
    write_interval(32'd0);
    send_command(set_pkg::CMD_ADD, 64'd1, 32'd7, 47'd3);
    send_command(set_pkg::CMD_LIST, 64'd1, '0, 47'd10);
    send_command(set_pkg::CMD_LIST, 64'd1, '0, 47'd11);
    write_interval(32'd65535);
    send_command(set_pkg::CMD_ADD, 64'd2, 32'hFFFF_FFFF, {NowW{1'b1}});
    send_command(set_pkg::CMD_ADD, 64'd3, 32'd1, 47'd65533);
    send_command(set_pkg::CMD_LIST, 64'd2, '0, 47'd131069);
    send_command(set_pkg::CMD_LIST, 64'd2, '0, 47'd131070);
    write_interval(32'hFFFF_0001);
    send_command(set_pkg::CMD_CLEAR, 64'd0, '0, '0);
  endtask

  task automatic random_item(logic [NowW-1:0] base);
    logic [IdW-1:0] id;
    logic [TmoW-1:0] tmo;
    int pick;
    pick = $urandom_range(99);
    id = ($urandom_range(9) == 0) ? {$urandom, $urandom} : id_pool[$urandom_range(7)];
    tmo = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(2000));
    if (pick < 50)
      send_command(set_pkg::CMD_ADD, id, tmo, base + NowW'($urandom_range(1000)));
    else if (pick < 70)
      send_command(set_pkg::CMD_REMOVE, id, tmo, NowW'({$urandom, $urandom}));
    else if (pick < 97)
      send_command(set_pkg::CMD_LIST, id, tmo, base + NowW'($urandom_range(3000)));
    else
      send_command(set_pkg::CMD_CLEAR, id, tmo, NowW'({$urandom, $urandom}));
  endtask

  task automatic test_random(int unsigned count);
    logic [NowW-1:0] base;
    foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
    base = NowW'({$urandom_range(32'hFFFF), $urandom});
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) write_interval(32'($urandom_range(1, 900)));
      if (n == count / 2) drain();                    // let everything come back
      stall_free = (n >= count / 4 && n < count / 4 + 40);
      random_item(base);
      base = base + NowW'($urandom_range(40));
    end
    stall_free = 1'b0;
  endtask

  initial begin
    bucket_ms = set_pkg::IntervalReset;
    foreach (tbl_used[i]) tbl_used[i] = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_table();
    test_intervals();
    test_random(230);
    drain();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
